FILE: rtl/frame_deframer_checker_top_defines.svh
// ----------------------------------------------------------------------------
// frame deframer checker assertion macros
// concurrent assertion helpers clocked on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef FRAME_DEFRAMER_CHECKER_TOP_DEFINES_SVH
`define FRAME_DEFRAMER_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define FDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define FDC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FDC_ASSERT(lbl, prop, msg)
`define FDC_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// shared types and constants of the frame deframer checker
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

	// frame layout
	localparam int MIN_FRAME       = 7;
	localparam int LEN_BIAS        = 5;
	localparam int OUTER_START     = 2;
	localparam int INNER_START     = 9;
	localparam int INNER_MIN_FRAME = MIN_FRAME + 4;
	localparam int CNT_W           = 9;

	// firmware quirk signatures
	localparam logic [7:0] QUIRK_IMU_LEN = 8'h11;
	localparam logic [7:0] QUIRK_ENC_LEN = 8'h25;
	localparam logic [7:0] QUIRK_MODULE  = 8'h01;
	localparam logic [7:0] QUIRK_TARGET  = 8'h02;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ERR_OK     = 3'd0,
		ERR_SHORT  = 3'd1,
		ERR_HEADER = 3'd2,
		ERR_LENGTH = 3'd3,
		ERR_TAIL   = 3'd4,
		ERR_OUTER  = 3'd5,
		ERR_INNER  = 3'd6
	} err_t;

	typedef enum logic [2:0] {
		CFG_START_BYTE = 3'd0,
		CFG_END_BYTE   = 3'd1,
		CFG_REQ_FIRST  = 3'd2,
		CFG_REQ_SECOND = 3'd3,
		CFG_RSP_FIRST  = 3'd4,
		CFG_RSP_SECOND = 3'd5,
		CFG_QUIRK_EN   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] req_first;
		logic [7:0] req_second;
		logic [7:0] rsp_first;
		logic [7:0] rsp_second;
		logic       quirk_en;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		start_byte: 8'hEE,
		end_byte:   8'h00,
		req_first:  8'h55,
		req_second: 8'hAA,
		rsp_first:  8'hAA,
		rsp_second: 8'h55,
		quirk_en:   1'b1
	};

	// one classified input word: an optional body byte and an optional verdict
	typedef struct packed {
		logic             has_body;
		logic [7:0]       body;
		logic             has_verdict;
		err_t             err;
		logic [7:0]       module_f;
		logic [7:0]       target_f;
		logic [7:0]       command_f;
		logic [CNT_W-1:0] count;
	} entry_t;

	// one result word
	typedef struct packed {
		logic             kind;
		logic [7:0]       payload;
		err_t             err;
		logic [7:0]       module_f;
		logic [7:0]       target_f;
		logic [7:0]       command_f;
		logic [CNT_W-1:0] count;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/fdc_front.sv
// ----------------------------------------------------------------------------
// fdc_front
// frame tracking, running sums and verdict classification, one byte a cycle while take is high
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_front import fdc_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       take,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	output logic       ent_valid,
	output entry_t     ent
);

	localparam int IW = $clog2(MAX_FRAME_BYTES + 3);
	localparam int CW = (IW > 9) ? IW : 9;

	logic [IW-1:0] idx_q;
	logic [7:0]    osum_q, isum_q;
	logic [7:0]    d0_q, d1_q;
	logic [7:0]    len_q, mod_q, tgt_q, cmd_q, first_q;
	logic          start_ok_q, req_q, rsp_q;

	logic [IW-1:0] n;
	logic [7:0]    osum_n, isum_n, inner_diff;
	logic [7:0]    len_n, mod_n, tgt_n, cmd_n, first_n;
	logic          start_ok_n, req_n, rsp_n;
	logic          pos0, pos1, pos2, pos3, pos4, pos5, pos6;
	logic          body_ok, qual, imu, enc, len_mismatch;
	err_t          err;
	logic [CNT_W-1:0] cnt;

	// byte position decode
	always_comb begin
		pos0 = (idx_q == IW'(0));
		pos1 = (idx_q == IW'(1));
		pos2 = (idx_q == IW'(2));
		pos3 = (idx_q == IW'(3));
		pos4 = (idx_q == IW'(4));
		pos5 = (idx_q == IW'(5));
		pos6 = (idx_q == IW'(6));
		n    = idx_q + IW'(1);
	end

	// running sums up to the byte two positions back, and captured header bytes including this byte
	always_comb begin
		osum_n = (idx_q >= IW'(OUTER_START)) ? osum_q + d0_q : osum_q;
		isum_n = (idx_q >= IW'(INNER_START)) ? isum_q + d0_q : isum_q;
		len_n   = pos1 ? rx_byte : len_q;
		mod_n   = pos2 ? rx_byte : mod_q;
		tgt_n   = pos3 ? rx_byte : tgt_q;
		cmd_n   = pos4 ? rx_byte : cmd_q;
		first_n = pos5 ? rx_byte : first_q;
		start_ok_n = start_ok_q | (pos0 && (rx_byte == cfg.start_byte));
		req_n = req_q | (pos6 && (first_q == cfg.req_first) && (rx_byte == cfg.req_second));
		rsp_n = rsp_q | (pos6 && (first_q == cfg.rsp_first) && (rx_byte == cfg.rsp_second));
		body_ok = (idx_q >= IW'(MIN_FRAME)) && (idx_q < IW'(MAX_FRAME_BYTES));
	end

	// verdict checks in priority order
	always_comb begin
		qual = cfg.quirk_en && (mod_n == QUIRK_MODULE) && (tgt_n == QUIRK_TARGET);
		imu  = qual && (len_n == QUIRK_IMU_LEN);
		enc  = qual && (len_n == QUIRK_ENC_LEN);
		len_mismatch = ((CW'(len_n) + CW'(LEN_BIAS)) != CW'(n));
		inner_diff   = isum_n - d0_q;
		priority if (n < IW'(MIN_FRAME)) begin
			err = ERR_SHORT;
		end else if (!start_ok_n) begin
			err = ERR_HEADER;
		end else if (n > IW'(MAX_FRAME_BYTES)) begin
			err = ERR_LENGTH;
		end else if (!(imu || enc) && len_mismatch) begin
			err = ERR_LENGTH;
		end else if (rx_byte != cfg.end_byte) begin
			err = ERR_TAIL;
		end else if (!imu && (osum_n != d1_q)) begin
			err = ERR_OUTER;
		end else if ((n >= IW'(INNER_MIN_FRAME)) && (req_n || rsp_n) &&
			(inner_diff != d0_q)) begin
			err = ERR_INNER;
		end else begin
			err = ERR_OK;
		end
		if ((n >= IW'(MIN_FRAME)) && (n <= IW'(MAX_FRAME_BYTES))) begin
			cnt = CNT_W'(n - IW'(MIN_FRAME));
		end else begin
			cnt = '0;
		end
	end

	// word handed to the queue
	always_comb begin
		ent.has_body    = body_ok;
		ent.body        = d0_q;
		ent.has_verdict = end_of_frame;
		ent.err         = err;
		ent.module_f    = mod_n;
		ent.target_f    = tgt_n;
		ent.command_f   = cmd_n;
		ent.count       = cnt;
		ent_valid       = take && (body_ok || end_of_frame);
	end

	// frame state, cleared after every verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			osum_q     <= '0;
			isum_q     <= '0;
			d0_q       <= '0;
			d1_q       <= '0;
			len_q      <= '0;
			mod_q      <= '0;
			tgt_q      <= '0;
			cmd_q      <= '0;
			first_q    <= '0;
			start_ok_q <= 1'b0;
			req_q      <= 1'b0;
			rsp_q      <= 1'b0;
		end else if (take) begin
			if (end_of_frame) begin
				idx_q      <= '0;
				osum_q     <= '0;
				isum_q     <= '0;
				d0_q       <= '0;
				d1_q       <= '0;
				len_q      <= '0;
				mod_q      <= '0;
				tgt_q      <= '0;
				cmd_q      <= '0;
				first_q    <= '0;
				start_ok_q <= 1'b0;
				req_q      <= 1'b0;
				rsp_q      <= 1'b0;
			end else begin
				if (idx_q <= IW'(MAX_FRAME_BYTES)) begin
					idx_q <= n;
				end
				osum_q     <= osum_n;
				isum_q     <= isum_n;
				d0_q       <= d1_q;
				d1_q       <= rx_byte;
				len_q      <= len_n;
				mod_q      <= mod_n;
				tgt_q      <= tgt_n;
				cmd_q      <= cmd_n;
				first_q    <= first_n;
				start_ok_q <= start_ok_n;
				req_q      <= req_n;
				rsp_q      <= rsp_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fdc_queue.sv
// ----------------------------------------------------------------------------
// fdc_queue
// short first-in first-out queue of classified words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_queue import fdc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_data,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	// status and head
	always_comb begin
		empty   = (cnt_q == QCNT_W'(0));
		full    = (cnt_q == QCNT_W'(QDEPTH));
		do_push = push && !full;
		do_pop  = pop && !empty;
		head    = mem_q[rd_ptr_q];
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fdc_back.sv
// ----------------------------------------------------------------------------
// fdc_back
// splits each queued word into its body byte result, its verdict result or both, body first
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_back import fdc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   q_empty,
	input  logic   pop,
	output logic   q_pop,
	output logic   empty,
	output res_t   res
);

	logic phase_q;
	logic show_body, take;

	// result selection
	always_comb begin
		show_body = head.has_body && !phase_q;
		take      = pop && !q_empty;
		q_pop     = take && !(show_body && head.has_verdict);
		empty     = q_empty;
		if (show_body) begin
			res.kind      = 1'b0;
			res.payload   = head.body;
			res.err       = ERR_OK;
			res.module_f  = '0;
			res.target_f  = '0;
			res.command_f = '0;
			res.count     = '0;
			res.last      = 1'b0;
		end else begin
			res.kind      = 1'b1;
			res.payload   = '0;
			res.err       = head.err;
			res.module_f  = head.module_f;
			res.target_f  = head.target_f;
			res.command_f = head.command_f;
			res.count     = head.count;
			res.last      = 1'b1;
		end
	end

	// body already delivered for the head word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= show_body && head.has_verdict;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/frame_deframer_checker_top.sv
// ----------------------------------------------------------------------------
// frame_deframer_checker_top
// byte-serial frame checker: streams body bytes and gives one verdict a frame
// ----------------------------------------------------------------------------
// usage
//   input queue: rx_byte and end_of_frame are taken when push is high and
//   full is low, one byte a cycle at most; end_of_frame marks the tail byte.
//   result queue: while empty is low the oldest result is on the result ports
//   and is taken when pop is high. a body byte has result_kind 0; the verdict
//   has result_kind 1 and run_last 1 and carries error_code, the header fields
//   and payload_count.
//   config: cfg_index/cfg_data written when cfg_valid is high, cfg_ready is
//   always high; an index past the list is dropped. write only while idle.
// timing
//   a body byte is emitted when the byte two positions later arrives. the
//   verdict comes out with the tail byte. bytes are taken every cycle while
//   full is low; a byte that yields a body result and a verdict needs a pop
//   for each, so output bandwidth of one result a cycle sets the sustained
//   rate. a four word queue parts the classifier from output.
// reset and stall
//   reset clears frame state and queue and restores register defaults.
//   if pop stays low the queue fills and full holds off further bytes.
// ----------------------------------------------------------------------------
`include "frame_deframer_checker_top_defines.svh"
`default_nettype none

module frame_deframer_checker_top import fdc_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	// input queue
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	// result queue
	output logic       empty,
	input  logic       pop,
	output logic       result_kind,
	output logic [7:0] payload_byte,
	output logic [2:0] error_code,
	output logic [7:0] module_field,
	output logic [7:0] target_field,
	output logic [7:0] command_field,
	output logic [8:0] payload_count,
	output logic       run_last,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t   cfg_q;
	entry_t ent, q_head;
	logic   ent_valid, take;
	logic   q_empty, q_full, q_pop;
	res_t   res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_START_BYTE: cfg_q.start_byte <= cfg_data;
				CFG_END_BYTE:   cfg_q.end_byte   <= cfg_data;
				CFG_REQ_FIRST:  cfg_q.req_first  <= cfg_data;
				CFG_REQ_SECOND: cfg_q.req_second <= cfg_data;
				CFG_RSP_FIRST:  cfg_q.rsp_first  <= cfg_data;
				CFG_RSP_SECOND: cfg_q.rsp_second <= cfg_data;
				CFG_QUIRK_EN:   cfg_q.quirk_en   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: classify each byte
	assign full = q_full;
	assign take = push && !q_full;

	fdc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.take        (take),
		.rx_byte     (rx_byte),
		.end_of_frame(end_of_frame),
		.ent_valid   (ent_valid),
		.ent         (ent)
	);

	// queue between front and back
	fdc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ent_valid),
		.wr_data(ent),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	// back: deliver results
	fdc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_empty(q_empty),
		.pop    (pop),
		.q_pop  (q_pop),
		.empty  (empty),
		.res    (res)
	);

	// result ports
	assign result_kind   = res.kind;
	assign payload_byte  = res.payload;
	assign error_code    = res.err;
	assign module_field  = res.module_f;
	assign target_field  = res.target_f;
	assign command_field = res.command_f;
	assign payload_count = res.count;
	assign run_last      = res.last;

	// checks
	`FDC_NEVER(a_no_push_when_full, ent_valid && q_full, "word pushed into full queue")
	`FDC_ASSERT(a_verdict_follows_body, (pop && !empty && !result_kind && q_head.has_verdict) |=> (!empty && result_kind), "verdict lost after body byte")
	`FDC_ASSERT(a_body_fields_clear, (!empty && !result_kind) |-> (error_code == ERR_OK && payload_count == '0 && !run_last), "body result carries verdict fields")

endmodule

`default_nettype wire

FILE: tb/frame_deframer_checker_top_test.sv
// ----------------------------------------------------------------------------
// frame_deframer_checker_top_test
// self-checking bench: byte frames go into the input queue, each result word
// is checked in order against an in-bench model of the deframer, over
// several register settings and several sender and receiver idling mixes
// ----------------------------------------------------------------------------
module frame_deframer_checker_top_test import fdc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int      FRAME_MAX     = 512;
	localparam int      SETTLE_CYCLES = 16;
	localparam int      PHASE_BYTES   = 105;
	localparam int      REPORT_LIMIT  = 10;
	localparam realtime RUN_LIMIT     = 2ms;

	// register index past the end of the list, must be dropped
	localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
	localparam logic [2:0] REG_ORDER [8] = '{
		CFG_START_BYTE, CFG_END_BYTE, CFG_REQ_FIRST, CFG_REQ_SECOND,
		CFG_RSP_FIRST, CFG_RSP_SECOND, CFG_QUIRK_EN, CFG_UNUSED_IDX
	};

	typedef enum int {
		FRM_GOOD, FRM_REQUEST, FRM_RESPONSE, FRM_QUIRK_IMU, FRM_QUIRK_ENC,
		FRM_BAD_START, FRM_BAD_LENGTH, FRM_BAD_TAIL, FRM_BAD_SUM,
		FRM_BAD_INNER, FRM_SHORT, FRM_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_word_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       push         = 1'b0;
	logic       full;
	logic [7:0] rx_byte      = 8'h00;
	logic       end_of_frame = 1'b0;
	logic       empty;
	logic       pop          = 1'b0;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [2:0] error_code;
	logic [7:0] module_field;
	logic [7:0] target_field;
	logic [7:0] command_field;
	logic [8:0] payload_count;
	logic       run_last;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index    = CFG_START_BYTE;
	logic [7:0] cfg_data     = 8'h00;

	frame_deframer_checker_top #(
		.MAX_FRAME_BYTES(FRAME_MAX)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.end_of_frame (end_of_frame),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.error_code   (error_code),
		.module_field (module_field),
		.target_field (target_field),
		.command_field(command_field),
		.payload_count(payload_count),
		.run_last     (run_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// stimulus and expectation stores
	rx_word_t pending_words [$];
	res_t     expected_words [$];
	rx_word_t next_word;
	int       mismatch_count = 0;
	int       send_idle_pct  = 0;
	int       recv_stall_pct = 0;

	// deframer model state
	cfg_t       shadow_cfg;
	int         frame_pos;
	logic [7:0] run_sum;
	logic [7:0] inner_acc;
	logic [7:0] lag_old;
	logic [7:0] lag_new;
	logic [7:0] len_seen;
	logic [7:0] hdr_module;
	logic [7:0] hdr_target;
	logic [7:0] hdr_command;
	logic [7:0] body_head;
	logic       start_ok;
	logic       req_seen;
	logic       rsp_seen;

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#RUN_LIMIT;
		$display("frame_deframer_checker_top verification failed");
		$finish;
	end

	function automatic void clear_frame_state();
		frame_pos   = 0;
		run_sum     = 8'h00;
		inner_acc   = 8'h00;
		lag_old     = 8'h00;
		lag_new     = 8'h00;
		len_seen    = 8'h00;
		hdr_module  = 8'h00;
		hdr_target  = 8'h00;
		hdr_command = 8'h00;
		body_head   = 8'h00;
		start_ok    = 1'b0;
		req_seen    = 1'b0;
		rsp_seen    = 1'b0;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [7:0] data);
		case (idx)
			CFG_START_BYTE: shadow_cfg.start_byte = data;
			CFG_END_BYTE:   shadow_cfg.end_byte   = data;
			CFG_REQ_FIRST:  shadow_cfg.req_first  = data;
			CFG_REQ_SECOND: shadow_cfg.req_second = data;
			CFG_RSP_FIRST:  shadow_cfg.rsp_first  = data;
			CFG_RSP_SECOND: shadow_cfg.rsp_second = data;
			CFG_QUIRK_EN:   shadow_cfg.quirk_en   = data[0];
			default: ;
		endcase
	endfunction

	// model of one accepted byte: queues the body word and the verdict it causes
	function automatic void predict_frame_byte(logic [7:0] b, logic eof);
		int         pos;
		int         fsize;
		logic [7:0] chk;
		logic [7:0] last_body;
		logic [7:0] inner_rest;
		logic       qual;
		logic       imu;
		logic       enc;
		res_t       word;

		pos = frame_pos;
		if (pos >= OUTER_START)
			run_sum = run_sum + lag_old;
		if (pos >= INNER_START)
			inner_acc = inner_acc + lag_old;
		// body byte leaves two positions late
		if (pos >= MIN_FRAME && pos < FRAME_MAX) begin
			word = '0;
			word.err = ERR_OK;
			word.payload = lag_old;
			expected_words.insert(expected_words.size(), word);
		end

		case (pos)
			0: if (b == shadow_cfg.start_byte) start_ok = 1'b1;
			1: len_seen = b;
			2: hdr_module = b;
			3: hdr_target = b;
			4: hdr_command = b;
			5: body_head = b;
			6: begin
				if (body_head == shadow_cfg.req_first && b == shadow_cfg.req_second)
					req_seen = 1'b1;
				if (body_head == shadow_cfg.rsp_first && b == shadow_cfg.rsp_second)
					rsp_seen = 1'b1;
			end
			default: ;
		endcase

		if (!eof) begin
			lag_old = lag_new;
			lag_new = b;
			if (frame_pos <= FRAME_MAX)
				frame_pos++;
			return;
		end

		// verdict on the tail byte, first failing check wins
		fsize      = pos + 1;
		chk        = lag_new;
		last_body  = lag_old;
		inner_rest = inner_acc - last_body;
		qual = shadow_cfg.quirk_en && hdr_module == QUIRK_MODULE &&
			hdr_target == QUIRK_TARGET;
		imu  = qual && len_seen == QUIRK_IMU_LEN;
		enc  = qual && len_seen == QUIRK_ENC_LEN;
		word = '0;
		word.kind = 1'b1;
		word.last = 1'b1;
		word.module_f  = hdr_module;
		word.target_f  = hdr_target;
		word.command_f = hdr_command;
		if (fsize < MIN_FRAME)
			word.err = ERR_SHORT;
		else if (!start_ok)
			word.err = ERR_HEADER;
		else if (fsize > FRAME_MAX)
			word.err = ERR_LENGTH;
		else if (!(imu || enc) && int'(len_seen) + LEN_BIAS != fsize)
			word.err = ERR_LENGTH;
		else if (b != shadow_cfg.end_byte)
			word.err = ERR_TAIL;
		else if (!imu && run_sum != chk)
			word.err = ERR_OUTER;
		else if (fsize >= INNER_MIN_FRAME && (req_seen || rsp_seen) &&
				inner_rest != last_body)
			word.err = ERR_INNER;
		else
			word.err = ERR_OK;
		if (fsize >= MIN_FRAME && fsize <= FRAME_MAX)
			word.count = 9'(fsize - MIN_FRAME);
		expected_words.insert(expected_words.size(), word);
		clear_frame_state();
	endfunction

	// build one frame of the given flavor under the current settings
	function automatic int queue_frame(frame_kind_t kind, int body_len);
		logic [7:0] body [$];
		logic [7:0] fb [$];
		logic [7:0] sum;
		logic [7:0] lb;
		logic       inner;
		logic       use_rsp;
		logic       quirk;
		int         n;
		rx_word_t   w;

		if (kind == FRM_SHORT || kind == FRM_NOISE) begin
			n = (kind == FRM_SHORT) ? $urandom_range(MIN_FRAME - 1, 1) :
				$urandom_range(24, 1);
			for (int k = 0; k < n; k++)
				fb.insert(fb.size(), 8'($urandom));
			if (kind == FRM_SHORT && $urandom_range(1))
				fb[0] = shadow_cfg.start_byte;
		end else begin
			inner = kind == FRM_REQUEST || kind == FRM_RESPONSE || kind == FRM_BAD_INNER;
			quirk = kind == FRM_QUIRK_IMU || kind == FRM_QUIRK_ENC;
			if (inner && body_len < 4)
				body_len = 4 + $urandom_range(8);
			for (int k = 0; k < body_len; k++)
				body.insert(body.size(), 8'($urandom));
			// inner header pair and trailing inner checksum
			if (inner) begin
				use_rsp = (kind == FRM_RESPONSE) || (kind == FRM_BAD_INNER && $urandom_range(1));
				body[0] = use_rsp ? shadow_cfg.rsp_first : shadow_cfg.req_first;
				body[1] = use_rsp ? shadow_cfg.rsp_second : shadow_cfg.req_second;
				sum = 8'h00;
				for (int k = 2; k < body_len - 1; k++)
					sum = sum + body[k];
				if (kind == FRM_BAD_INNER)
					sum = sum + 8'($urandom_range(255, 1));
				body[body_len - 1] = sum;
			end
			if (kind == FRM_BAD_START)
				fb.insert(fb.size(), shadow_cfg.start_byte ^ 8'($urandom_range(255, 1)));
			else
				fb.insert(fb.size(), shadow_cfg.start_byte);
			lb = 8'(body_len + 2);
			if (kind == FRM_BAD_LENGTH)
				lb = lb + 8'($urandom_range(255, 1));
			if (kind == FRM_QUIRK_IMU)
				lb = QUIRK_IMU_LEN;
			if (kind == FRM_QUIRK_ENC)
				lb = QUIRK_ENC_LEN;
			fb.insert(fb.size(), lb);
			if (quirk || $urandom_range(3) == 0) begin
				fb.insert(fb.size(), QUIRK_MODULE);
				fb.insert(fb.size(), QUIRK_TARGET);
			end else begin
				fb.insert(fb.size(), 8'($urandom));
				fb.insert(fb.size(), 8'($urandom));
			end
			fb.insert(fb.size(), 8'($urandom));
			foreach (body[k])
				fb.insert(fb.size(), body[k]);
			sum = 8'h00;
			foreach (fb[k])
				sum = sum + fb[k];
			if (kind == FRM_QUIRK_IMU)
				sum = 8'($urandom);
			else if (kind == FRM_BAD_SUM)
				sum = sum + 8'($urandom_range(255, 1));
			fb.insert(fb.size(), sum);
			if (kind == FRM_BAD_TAIL)
				fb.insert(fb.size(), shadow_cfg.end_byte ^ 8'($urandom_range(255, 1)));
			else
				fb.insert(fb.size(), shadow_cfg.end_byte);
		end
		foreach (fb[k]) begin
			w.data = fb[k];
			w.last = (k == fb.size() - 1);
			pending_words.insert(pending_words.size(), w);
		end
		return fb.size();
	endfunction

	// mostly well-formed frames, the rest single defects and noise
	function automatic int queue_random_frame();
		int          r;
		int          body_len;
		frame_kind_t kind;

		r = $urandom_range(99);
		if (r < 20)      kind = FRM_GOOD;
		else if (r < 35) kind = FRM_REQUEST;
		else if (r < 45) kind = FRM_RESPONSE;
		else if (r < 52) kind = FRM_QUIRK_IMU;
		else if (r < 58) kind = FRM_QUIRK_ENC;
		else if (r < 64) kind = FRM_BAD_START;
		else if (r < 70) kind = FRM_BAD_LENGTH;
		else if (r < 76) kind = FRM_BAD_TAIL;
		else if (r < 82) kind = FRM_BAD_SUM;
		else if (r < 88) kind = FRM_BAD_INNER;
		else if (r < 94) kind = FRM_SHORT;
		else             kind = FRM_NOISE;
		body_len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 0);
		return queue_frame(kind, body_len);
	endfunction

	function automatic cfg_t phase_setting(int phase);
		cfg_t c;

		c.start_byte = 8'($urandom);
		c.end_byte   = 8'($urandom);
		c.req_first  = 8'($urandom);
		c.req_second = 8'($urandom);
		c.rsp_first  = 8'($urandom);
		c.rsp_second = 8'($urandom);
		c.quirk_en   = 1'($urandom_range(1));
		case (phase)
			1: c = CFG_RESET;
			2: c = '0;
			3: c = '1;
			4: c.quirk_en = 1'b1;
			6: begin
				// request and response pair alike, both flags at once
				c.rsp_first  = c.req_first;
				c.rsp_second = c.req_second;
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] reg_value(cfg_t c, logic [2:0] idx);
		case (idx)
			CFG_START_BYTE: return c.start_byte;
			CFG_END_BYTE:   return c.end_byte;
			CFG_REQ_FIRST:  return c.req_first;
			CFG_REQ_SECOND: return c.req_second;
			CFG_RSP_FIRST:  return c.rsp_first;
			CFG_RSP_SECOND: return c.rsp_second;
			CFG_QUIRK_EN:   return {7'($urandom), c.quirk_en};
			default:        return 8'($urandom);
		endcase
	endfunction

	// write every register, plus the unused index, back to back
	task automatic write_setting(cfg_t c);
		logic [7:0] data;

		foreach (REG_ORDER[k]) begin
			data = reg_value(c, REG_ORDER[k]);
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[k];
			cfg_data  <= data;
			do
				@(posedge clk);
			while (!(cfg_valid && cfg_ready));
			apply_reg(REG_ORDER[k], data);
		end
		cfg_valid <= 1'b0;
	endtask

	// all bytes sent and all results back, then let the pipeline drain
	task automatic wait_drained();
		while (pending_words.size() != 0 || push || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void log_failure(string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%s", what);
	endfunction

	// input word driver
	always @(posedge clk) begin
		if (push && !full)
			predict_frame_byte(rx_byte, end_of_frame);
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && full) begin
			// hold the offered word
		end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			next_word = pending_words.pop_front();
			push         <= 1'b1;
			rx_byte      <= next_word.data;
			end_of_frame <= next_word.last;
		end else begin
			push <= 1'b0;
		end
	end

	// result word monitor
	always @(posedge clk) begin
		res_t want;
		res_t got;

		if (pop && !empty) begin
			got.kind      = result_kind;
			got.payload   = payload_byte;
			got.err       = err_t'(error_code);
			got.module_f  = module_field;
			got.target_f  = target_field;
			got.command_f = command_field;
			got.count     = payload_count;
			got.last      = run_last;
			if (expected_words.size() == 0) begin
				log_failure($sformatf("unexpected word kind=%0d byte=%02h err=%0d",
					got.kind, got.payload, got.err));
			end else begin
				want = expected_words.pop_front();
				if (got.kind !== want.kind || got.payload !== want.payload ||
						got.err !== want.err || got.module_f !== want.module_f ||
						got.target_f !== want.target_f || got.command_f !== want.command_f ||
						got.count !== want.count || got.last !== want.last)
					log_failure($sformatf(
						{"mismatch exp kind=%0d byte=%02h err=%0d mod=%02h tgt=%02h cmd=%02h",
						" cnt=%0d last=%0d, got kind=%0d byte=%02h err=%0d mod=%02h",
						" tgt=%02h cmd=%02h cnt=%0d last=%0d"},
						want.kind, want.payload, want.err, want.module_f, want.target_f,
						want.command_f, want.count, want.last, got.kind, got.payload,
						got.err, got.module_f, got.target_f, got.command_f, got.count,
						got.last));
			end
		end
		pop <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// reset, phases of stimulus, final verdict
	initial begin
		int added;

		shadow_cfg = CFG_RESET;
		clear_frame_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under reset settings
		added = queue_frame(FRM_GOOD, 0);
		added = queue_frame(FRM_SHORT, 0);
		added = queue_frame(FRM_REQUEST, 4);
		added = queue_frame(FRM_QUIRK_IMU, 0);
		wait_drained();

		for (int phase = 1; phase <= 6; phase++) begin
			write_setting(phase_setting(phase));
			case (phase)
				2:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
				3:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
				4, 6:    begin send_idle_pct = 23; recv_stall_pct = 23; end
				default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			endcase
			added = 0;
			while (added < PHASE_BYTES)
				added += queue_random_frame();
			// largest accepted frame, then one byte past the bound
			if (phase == 4)
				added += queue_frame(FRM_QUIRK_ENC, FRAME_MAX - MIN_FRAME);
			if (phase == 5)
				added += queue_frame(FRM_GOOD, FRAME_MAX - MIN_FRAME + 1);
			wait_drained();
		end

		mismatch_count += expected_words.size();
		if (mismatch_count == 0)
			$display("frame_deframer_checker_top verification clean");
		else
			$display("frame_deframer_checker_top verification failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/fdc_pkg.sv
rtl/fdc_front.sv
rtl/fdc_queue.sv
rtl/fdc_back.sv
rtl/frame_deframer_checker_top.sv
tb/frame_deframer_checker_top_test.sv
